// ===== design/bbadc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbadc_pkg
// Shared types, codes and port byte constants of the serial converter port
// sequencer.
// ----------------------------------------------------------------------------
package bbadc_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam logic [15:0] POLL_LIMIT_RST = 16'd10000;

  // Item opcodes.
  localparam logic [1:0] OP_CONT = 2'd0;
  localparam logic [1:0] OP_DAC  = 2'd1;
  localparam logic [1:0] OP_ADC  = 2'd2;

  // Port byte patterns.
  localparam logic [7:0] BYTE_DAC_BASE = 8'h22;
  localparam logic [7:0] BYTE_DAC_CLK  = 8'h23;
  localparam logic [7:0] BYTE_DAC_END  = 8'h32;
  localparam logic [7:0] BYTE_ADC_LOW  = 8'hFC;
  localparam logic [7:0] BYTE_ADC_HIGH = 8'hFD;
  localparam logic [7:0] BYTE_ADC_END  = 8'hFE;
  localparam logic [7:0] BYTE_DATA_BIT = 8'h80;

  // Fixed bit positions of the result word; the sample and the timeout
  // flag follow above them.
  localparam int OUT_BYTE_LSB = 0;
  localparam int OUT_DRIVE    = 8;
  localparam int OUT_BUSY     = 9;
  localparam int OUT_DONE     = 10;
  localparam int OUT_ADC_LSB  = 11;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_DAC_LOW    = 4'd1,
    PH_DAC_HIGH   = 4'd2,
    PH_DAC_END    = 4'd3,
    PH_ADC_POLL   = 4'd4,
    PH_ADC_FC     = 4'd5,
    PH_ADC_CLK    = 4'd6,
    PH_ADC_SAMPLE = 4'd7,
    PH_ADC_END    = 4'd8
  } phase_t;

  // Per-tick flags handed from the sequencer to the result register.
  typedef struct packed {
    logic [7:0] port_byte;
    logic       port_drive;
    logic       busy;
    logic       done;
    logic       timed_out;
  } seq_res_t;

endpackage
`default_nettype wire

// ===== design/bbadc_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbadc_seq
// Phase sequencer: advances one port tick for each step and reports the byte
// driven, the status flags and the sample of that tick.
// ----------------------------------------------------------------------------
module bbadc_seq
  import bbadc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire logic [1:0]             opcode,
  input  wire logic [15:0]            dac_value,
  input  wire logic                   status_line,
  input  wire logic [15:0]            poll_limit,
  output seq_res_t                    res,
  output logic      [SAMPLE_BITS-1:0] adc_result
);

  localparam int CNT_W = $clog2(SAMPLE_BITS + 1);
  localparam logic [15:0] FULL_SCALE = 16'((1 << SAMPLE_BITS) - 1);

  phase_t                 phase, phase_next;
  logic [SAMPLE_BITS-1:0] shift_word, shift_word_next;
  logic [CNT_W-1:0]       bit_count, bit_count_next;
  logic [15:0]            poll_count, poll_count_next;
  logic [7:0]             port_latch;

  logic [CNT_W-1:0]       bit_count_inc;
  logic                   last_bit;
  logic [15:0]            poll_inc;
  logic                   poll_expired;
  logic [7:0]             data_bit;
  logic [7:0]             tick_byte;
  logic                   tick_drive;
  logic                   tick_done;
  logic                   tick_tmo;

  assign bit_count_inc = bit_count + 1'b1;
  assign last_bit      = bit_count_inc >= CNT_W'(SAMPLE_BITS);
  assign poll_inc      = poll_count + 16'd1;
  assign poll_expired  = (poll_inc >= poll_limit) || (poll_inc == 16'd0);
  assign data_bit      = shift_word[SAMPLE_BITS-1] ? BYTE_DATA_BIT : 8'h00;

  // Next phase.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: begin
        if (opcode == OP_DAC) begin
          phase_next = PH_DAC_LOW;
        end else if (opcode == OP_ADC) begin
          phase_next = PH_ADC_POLL;
        end
      end
      PH_DAC_LOW:    phase_next = PH_DAC_HIGH;
      PH_DAC_HIGH:   phase_next = last_bit ? PH_DAC_END : PH_DAC_LOW;
      PH_DAC_END:    phase_next = PH_IDLE;
      PH_ADC_POLL: begin
        if (!status_line) begin
          phase_next = PH_ADC_FC;
        end else if (poll_expired) begin
          phase_next = PH_IDLE;
        end
      end
      PH_ADC_FC:     phase_next = PH_ADC_CLK;
      PH_ADC_CLK:    phase_next = PH_ADC_SAMPLE;
      PH_ADC_SAMPLE: phase_next = last_bit ? PH_ADC_END : PH_ADC_CLK;
      PH_ADC_END:    phase_next = PH_IDLE;
      default:       phase_next = PH_IDLE;
    endcase
  end

  // Port byte, flags and datapath updates of this tick.
  always_comb begin
    tick_byte       = 8'h00;
    tick_drive      = 1'b0;
    tick_done       = 1'b0;
    tick_tmo        = 1'b0;
    adc_result      = '0;
    shift_word_next = shift_word;
    bit_count_next  = bit_count;
    poll_count_next = poll_count;
    unique case (phase)
      PH_IDLE: begin
        if (opcode == OP_DAC) begin
          shift_word_next = (dac_value > FULL_SCALE) ? FULL_SCALE[SAMPLE_BITS-1:0]
                                                     : dac_value[SAMPLE_BITS-1:0];
          bit_count_next  = '0;
          tick_byte       = BYTE_DAC_BASE;
          tick_drive      = 1'b1;
        end else if (opcode == OP_ADC) begin
          shift_word_next = '0;
          bit_count_next  = '0;
          poll_count_next = 16'd0;
          tick_byte       = BYTE_ADC_LOW;
          tick_drive      = 1'b1;
        end
      end
      PH_DAC_LOW: begin
        tick_byte  = data_bit | BYTE_DAC_BASE;
        tick_drive = 1'b1;
      end
      PH_DAC_HIGH: begin
        tick_byte       = data_bit | BYTE_DAC_CLK;
        tick_drive      = 1'b1;
        shift_word_next = shift_word << 1;
        bit_count_next  = bit_count_inc;
      end
      PH_DAC_END: begin
        tick_byte  = BYTE_DAC_END;
        tick_drive = 1'b1;
        tick_done  = 1'b1;
      end
      PH_ADC_POLL: begin
        if (!status_line) begin
          tick_byte  = BYTE_ADC_HIGH;
          tick_drive = 1'b1;
        end else begin
          poll_count_next = poll_inc;
          tick_done       = poll_expired;
          tick_tmo        = poll_expired;
        end
      end
      PH_ADC_FC: begin
        tick_byte  = BYTE_ADC_LOW;
        tick_drive = 1'b1;
      end
      PH_ADC_CLK: begin
        tick_byte  = BYTE_ADC_HIGH;
        tick_drive = 1'b1;
      end
      PH_ADC_SAMPLE: begin
        // The converter drives its data inverted on the status line.
        tick_byte       = BYTE_ADC_LOW;
        tick_drive      = 1'b1;
        shift_word_next = {shift_word[SAMPLE_BITS-2:0], ~status_line};
        bit_count_next  = bit_count_inc;
      end
      PH_ADC_END: begin
        tick_byte  = BYTE_ADC_END;
        tick_drive = 1'b1;
        tick_done  = 1'b1;
        adc_result = shift_word;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.port_byte  = tick_drive ? tick_byte : port_latch;
    res.port_drive = tick_drive;
    res.busy       = (phase_next != PH_IDLE);
    res.done       = tick_done;
    res.timed_out  = tick_tmo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      shift_word <= '0;
      bit_count  <= '0;
      poll_count <= 16'd0;
      port_latch <= 8'h00;
    end else if (step) begin
      phase      <= phase_next;
      shift_word <= shift_word_next;
      bit_count  <= bit_count_next;
      poll_count <= poll_count_next;
      if (tick_drive) begin
        port_latch <= tick_byte;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/bitbang_adc_dac_port_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitbang_adc_dac_port_sequencer
// Port sequencer for a bit-banged serial DAC and ADC, one port tick per item.
// ----------------------------------------------------------------------------
// Each item on the slave stream is one tick of the converter port. tuser
// carries the opcode (continue, start a DAC write, start an ADC read) and
// tdata carries the DAC value and the status line sampled after the previous
// tick's byte. For every accepted item exactly one result item leaves on the
// master stream, in order: the port byte for this tick, whether it is newly
// driven, the busy and done flags, the converted sample on the done tick of a
// read, and the timeout flag.
// A DAC write takes 2 * SAMPLE_BITS + 2 ticks; an ADC read takes one tick,
// the polling ticks, then 2 * SAMPLE_BITS + 3 ticks, or ends early when the
// poll limit runs out. Starts while a sequence runs are ignored.
// The result of an item is registered and appears in the cycle after the item
// is accepted. Unless the receiver stalls, the block takes one item per cycle,
// set by the single phase register that each tick updates. The result register
// parts the two sides: while a result waits for a stalled receiver, no new item
// is accepted; one is taken in the same cycle as the waiting result is taken.
// The poll limit is written through the cfg channel, which is always ready.
// Reset returns the sequencer to idle, clears the port latch, empties the
// output register, and sets the poll limit to 10000.
// ----------------------------------------------------------------------------
module bitbang_adc_dac_port_sequencer
  import bbadc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int OUT_BITS = OUT_ADC_LSB + SAMPLE_BITS + 1,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // Input stream.
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [23:0]      s_tdata,   // dac_value[15:0], status_line[16], zero pad
  input  wire logic [1:0]       s_tuser,   // opcode[1:0]
  // Result stream.
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // port_byte[7:0], port_drive, busy_res,
                                           // done_res, adc_result, timed_out, zero pad
  // Poll limit register write.
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [15:0]      cfg_data
);

  logic [15:0]            poll_limit;
  logic                   step;
  seq_res_t               res;
  logic [SAMPLE_BITS-1:0] adc_result;
  logic [OUT_W-1:0]       result_word;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign step      = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit <= POLL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      poll_limit <= cfg_data;
    end
  end

  bbadc_seq #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .opcode      (s_tuser),
    .dac_value   (s_tdata[15:0]),
    .status_line (s_tdata[16]),
    .poll_limit  (poll_limit),
    .res         (res),
    .adc_result  (adc_result)
  );

  // Pack the result fields from the lowest bit up.
  always_comb begin
    result_word                              = '0;
    result_word[OUT_BYTE_LSB +: 8]           = res.port_byte;
    result_word[OUT_DRIVE]                   = res.port_drive;
    result_word[OUT_BUSY]                    = res.busy;
    result_word[OUT_DONE]                    = res.done;
    result_word[OUT_ADC_LSB +: SAMPLE_BITS]  = adc_result;
    result_word[OUT_ADC_LSB + SAMPLE_BITS]   = res.timed_out;
  end

  // Result register: loaded on each accepted item, held while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= result_word;
    end
  end

endmodule
`default_nettype wire

// ===== design/bbadc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbadc_checker
// Port-level checks of the sequencer: result hold under stall, no overrun of
// the result register, port latch behavior and sequence framing.
// ----------------------------------------------------------------------------
module bbadc_checker
  import bbadc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int OUT_BITS = OUT_ADC_LSB + SAMPLE_BITS + 1,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_tvalid,
  input wire logic             s_tready,
  input wire logic [23:0]      s_tdata,
  input wire logic [1:0]       s_tuser,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata,
  input wire logic             cfg_valid,
  input wire logic             cfg_ready,
  input wire logic [15:0]      cfg_data
);

  logic [7:0] last_byte;
  logic       last_busy;
  logic       out_take;

  assign out_take = m_tvalid && m_tready;

  // Byte and busy flag of the last result taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_byte <= 8'h00;
      last_busy <= 1'b0;
    end else if (out_take) begin
      last_byte <= m_tdata[OUT_BYTE_LSB +: 8];
      last_busy <= m_tdata[OUT_BUSY];
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> !m_tvalid || m_tready)
    else $error("item accepted over a waiting result");

  a_latch_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[OUT_DRIVE] |-> m_tdata[OUT_BYTE_LSB +: 8] == last_byte)
    else $error("port byte changed without a drive");

  a_done_framed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_DONE] |-> last_busy && !m_tdata[OUT_BUSY])
    else $error("done without a running sequence");

  // Inputs that the checks above do not look at.
  logic unused_ok;
  assign unused_ok = ^{s_tdata, s_tuser, cfg_valid, cfg_ready, cfg_data};

endmodule

bind bitbang_adc_dac_port_sequencer bbadc_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_bbadc_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .s_tdata   (s_tdata),
  .s_tuser   (s_tuser),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_data  (cfg_data)
);
`default_nettype wire

// ===== test/port_tick_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// port_tick_checker
// Watches the item, result and poll limit channels of the port sequencer,
// predicts the result of every accepted item and compares it field by field.
// ----------------------------------------------------------------------------
module port_tick_checker
  import bbadc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int OUT_W = ((OUT_ADC_LSB + SAMPLE_BITS + 1 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [23:0]      s_tdata,
  input  logic [1:0]       s_tuser,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [15:0]      cfg_data,
  output int               errors,
  output int               pending
);

  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;

  typedef struct packed {
    logic [7:0]             port_byte;
    logic                   port_drive;
    logic                   busy;
    logic                   done;
    logic [SAMPLE_BITS-1:0] adc_word;
    logic                   timed_out;
  } port_tick_t;

  // Predicted sequencer state.
  phase_t                 seq_phase;
  logic [SAMPLE_BITS-1:0] shift_word;
  logic [4:0]             bit_count;
  logic [15:0]            poll_count;
  logic [15:0]            poll_limit;
  logic [7:0]             port_latch;

  port_tick_t expected_ticks[$];
  port_tick_t want;
  port_tick_t got;
  int         err_count = 0;

  assign errors  = err_count;
  assign pending = expected_ticks.size();

  // Advances the predicted sequencer by one port tick and returns its result.
  function automatic port_tick_t predict_port_tick(input logic [1:0] opcode,
                                                   input logic [15:0] dac_value,
                                                   input logic status_line);
    port_tick_t r;
    logic [7:0] drive_byte;
    r = '0;
    drive_byte = '0;
    case (seq_phase)
      PH_IDLE: begin
        if (opcode == OP_DAC) begin
          shift_word = (dac_value > 16'(FULL_SCALE)) ? FULL_SCALE
                                                     : dac_value[SAMPLE_BITS-1:0];
          bit_count = '0;
          drive_byte = BYTE_DAC_BASE;
          r.port_drive = 1'b1;
          seq_phase = PH_DAC_LOW;
        end else if (opcode == OP_ADC) begin
          shift_word = '0;
          bit_count = '0;
          poll_count = '0;
          drive_byte = BYTE_ADC_LOW;
          r.port_drive = 1'b1;
          seq_phase = PH_ADC_POLL;
        end
      end
      PH_DAC_LOW: begin
        drive_byte = (shift_word[SAMPLE_BITS-1] ? BYTE_DATA_BIT : 8'h00) | BYTE_DAC_BASE;
        r.port_drive = 1'b1;
        seq_phase = PH_DAC_HIGH;
      end
      PH_DAC_HIGH: begin
        drive_byte = (shift_word[SAMPLE_BITS-1] ? BYTE_DATA_BIT : 8'h00) | BYTE_DAC_CLK;
        r.port_drive = 1'b1;
        shift_word = shift_word << 1;
        bit_count = bit_count + 5'd1;
        seq_phase = (bit_count >= 5'(SAMPLE_BITS)) ? PH_DAC_END : PH_DAC_LOW;
      end
      PH_DAC_END: begin
        drive_byte = BYTE_DAC_END;
        r.port_drive = 1'b1;
        r.done = 1'b1;
        seq_phase = PH_IDLE;
      end
      PH_ADC_POLL: begin
        if (!status_line) begin
          drive_byte = BYTE_ADC_HIGH;
          r.port_drive = 1'b1;
          seq_phase = PH_ADC_FC;
        end else begin
          poll_count = poll_count + 16'd1;
          if (poll_count >= poll_limit || poll_count == 16'd0) begin
            r.done = 1'b1;
            r.timed_out = 1'b1;
            seq_phase = PH_IDLE;
          end
        end
      end
      PH_ADC_FC: begin
        drive_byte = BYTE_ADC_LOW;
        r.port_drive = 1'b1;
        seq_phase = PH_ADC_CLK;
      end
      PH_ADC_CLK: begin
        drive_byte = BYTE_ADC_HIGH;
        r.port_drive = 1'b1;
        seq_phase = PH_ADC_SAMPLE;
      end
      PH_ADC_SAMPLE: begin
        drive_byte = BYTE_ADC_LOW;
        r.port_drive = 1'b1;
        // A low status line reads as a one bit.
        shift_word = {shift_word[SAMPLE_BITS-2:0], ~status_line};
        bit_count = bit_count + 5'd1;
        seq_phase = (bit_count >= 5'(SAMPLE_BITS)) ? PH_ADC_END : PH_ADC_CLK;
      end
      PH_ADC_END: begin
        drive_byte = BYTE_ADC_END;
        r.port_drive = 1'b1;
        r.done = 1'b1;
        r.adc_word = shift_word;
        seq_phase = PH_IDLE;
      end
      default: seq_phase = PH_IDLE;
    endcase
    if (r.port_drive) port_latch = drive_byte;
    r.port_byte = port_latch;
    r.busy = (seq_phase != PH_IDLE);
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_val,
                                      input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      seq_phase = PH_IDLE;
      shift_word = '0;
      bit_count = '0;
      poll_count = '0;
      poll_limit = POLL_LIMIT_RST;
      port_latch = '0;
      expected_ticks.delete();
    end else begin
      if (cfg_valid && cfg_ready) poll_limit = cfg_data;
      if (m_tvalid && m_tready) begin
        got.port_byte  = m_tdata[OUT_BYTE_LSB +: 8];
        got.port_drive = m_tdata[OUT_DRIVE];
        got.busy       = m_tdata[OUT_BUSY];
        got.done       = m_tdata[OUT_DONE];
        got.adc_word   = m_tdata[OUT_ADC_LSB +: SAMPLE_BITS];
        got.timed_out  = m_tdata[OUT_ADC_LSB + SAMPLE_BITS];
        if (expected_ticks.size() == 0) begin
          $error("result item 0x%0h arrived with no result expected", m_tdata);
          err_count++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("port_byte", 32'(want.port_byte), 32'(got.port_byte));
          check_field("port_drive", 32'(want.port_drive), 32'(got.port_drive));
          check_field("busy_res", 32'(want.busy), 32'(got.busy));
          check_field("done_res", 32'(want.done), 32'(got.done));
          check_field("adc_result", 32'(want.adc_word), 32'(got.adc_word));
          check_field("timed_out", 32'(want.timed_out), 32'(got.timed_out));
        end
      end
      if (s_tvalid && s_tready)
        expected_ticks.push_back(predict_port_tick(s_tuser, s_tdata[15:0], s_tdata[16]));
    end
  end

  final begin
    if (expected_ticks.size() != 0) begin
      $error("%0d expected result items never arrived", expected_ticks.size());
    end
  end

endmodule

// ===== test/bitbang_adc_dac_port_sequencer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitbang_adc_dac_port_sequencer_tb
// Drives DAC write and ADC read tick sequences with random gaps and stalls,
// across several poll limits, and lets a checker compare every result item.
// ----------------------------------------------------------------------------
module bitbang_adc_dac_port_sequencer_tb;
  import bbadc_pkg::*;

  localparam int OUT_W = ((OUT_ADC_LSB + SAMPLE_BITS_DEF + 1 + 7) / 8) * 8;
  // Opcode with no meaning to the sequencer; it must act as a plain tick.
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 5000;
  localparam int TARGET_ITEMS = 330;
  localparam int PHASE_COUNT  = 6;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [23:0]      s_tdata = '0;   // dac_value[15:0], status_line[16], zero pad
  logic [1:0]       s_tuser = OP_CONT;  // opcode[1:0]
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;        // port_byte[7:0], port_drive, busy_res,
                                    // done_res, adc_result, timed_out, zero pad
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [15:0]      cfg_data = '0;

  int errors;
  int pending;
  int items_sent  = 0;
  int idle_cycles = 0;
  // When set, neither side idles; the sink still honors a hold request.
  bit quiet = 1'b0;
  // Asks the sink for one long hold-off; the sink clears it when it starts.
  bit hold_req = 1'b0;

  always #1 clk = ~clk;

  bitbang_adc_dac_port_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  port_tick_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  // Gap lengths for either side: mostly none, often short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Opcode for a tick inside a sequence. A noisy sequence now and then offers
  // a start, or the unused opcode, which the busy sequencer must ignore.
  function automatic logic [1:0] tick_op(input bit noisy);
    if (noisy && $urandom_range(0, 3) == 0) return 2'($urandom_range(0, 3));
    return OP_CONT;
  endfunction

  function automatic logic [15:0] any_dac();
    return 16'($urandom_range(0, 65535));
  endfunction

  // DAC values are mostly in range; the rest exercise the clamp.
  function automatic logic [15:0] pick_dac();
    if ($urandom_range(0, 3) == 0) return any_dac();
    return 16'($urandom_range(0, 4095));
  endfunction

  // Offers one item and returns at the edge where it is accepted. tvalid stays
  // high when the next item follows with no gap.
  task automatic send_tick(input logic [1:0] op, input logic [15:0] dac,
                           input logic status);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, status, dac};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // A full DAC write: the start tick, one tick per half bit, and the end tick.
  // The status line means nothing here, so it is random.
  task automatic dac_write(input logic [15:0] value, input bit noisy,
                           input logic [1:0] end_op);
    send_tick(OP_DAC, value, 1'($urandom_range(0, 1)));
    repeat (2 * SAMPLE_BITS_DEF) send_tick(tick_op(noisy), any_dac(),
                                           1'($urandom_range(0, 1)));
    send_tick(end_op, any_dac(), 1'($urandom_range(0, 1)));
  endtask

  // An ADC read whose converter stays busy for the given number of polls and
  // then returns the given word. If the polls run past the limit the read
  // times out, and the remaining ticks hit an idle sequencer.
  task automatic adc_read(input int highs, input logic [SAMPLE_BITS_DEF-1:0] word,
                          input bit noisy, input logic [1:0] end_op);
    send_tick(OP_ADC, any_dac(), 1'($urandom_range(0, 1)));
    repeat (highs) send_tick(tick_op(noisy), any_dac(), 1'b1);
    send_tick(tick_op(noisy), any_dac(), 1'b0);
    send_tick(tick_op(noisy), any_dac(), 1'($urandom_range(0, 1)));
    for (int i = SAMPLE_BITS_DEF - 1; i >= 0; i--) begin
      send_tick(tick_op(noisy), any_dac(), 1'($urandom_range(0, 1)));
      // Bits are sampled inverted: a low line is a one.
      send_tick(tick_op(noisy), any_dac(), ~word[i]);
    end
    send_tick(end_op, any_dac(), 1'($urandom_range(0, 1)));
  endtask

  // Writes the poll limit once every result in flight has been taken. The
  // sequencer itself may still be in the middle of a read.
  task automatic set_poll_limit(input logic [15:0] value);
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One random piece of traffic: a write, a read, or a few stray ticks.
  task automatic random_traffic(input int lim);
    int  r;
    int  highs;
    bit  noisy;
    r = $urandom_range(0, 99);
    noisy = ($urandom_range(0, 3) == 0);
    if (r < 40) begin
      dac_write(pick_dac(), noisy, tick_op(noisy));
    end else if (r < 90) begin
      // Small limits get polls right around the limit, so that both the last
      // poll before a timeout and the timeout itself come up.
      if (lim <= 16 && $urandom_range(0, 1) == 1)
        highs = $urandom_range((lim > 0) ? lim - 1 : 0, lim + 1);
      else
        highs = $urandom_range(0, 3);
      adc_read(highs, SAMPLE_BITS_DEF'($urandom_range(0, 4095)), noisy, tick_op(noisy));
    end else begin
      repeat ($urandom_range(1, 4))
        send_tick((r < 95) ? OP_CONT : OP_NONE, any_dac(), 1'($urandom_range(0, 1)));
    end
  endtask

  // Sink side: random stalls of the result stream, with one long hold-off on
  // request so that the result register fills and the input stalls.
  initial begin
    int stall;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Watchdog: the run is stuck if no channel moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("bitbang_adc_dac_port_sequencer_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int lim;
    int phase_end;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Plain and unused opcodes on an idle sequencer drive
    // nothing and keep the port latch.
    send_tick(OP_CONT, 16'hFFFF, 1'b1);
    send_tick(OP_NONE, 16'h0000, 1'b0);

    // DAC extremes, the clamp, and starts offered on the done tick.
    dac_write(16'h0000, 1'b0, OP_CONT);
    dac_write(16'h0FFF, 1'b0, OP_DAC);
    dac_write(16'h1000, 1'b0, OP_ADC);
    dac_write(16'hFFFF, 1'b1, OP_NONE);
    dac_write(16'h0800, 1'b0, OP_CONT);
    dac_write(16'h0AAA, 1'b0, OP_CONT);

    // Reads at the reset poll limit: ready at once, ready after a few polls,
    // and a start offered on the done tick.
    adc_read(0, 12'hFFF, 1'b0, OP_ADC);
    adc_read(3, 12'h000, 1'b0, OP_DAC);
    adc_read(0, 12'hA5C, 1'b1, OP_CONT);

    // A poll limit written in the middle of a read applies at once: after
    // three busy polls, a limit of two makes the next busy poll time out.
    send_tick(OP_ADC, any_dac(), 1'b1);
    repeat (3) send_tick(OP_CONT, any_dac(), 1'b1);
    set_poll_limit(16'd2);
    send_tick(OP_CONT, any_dac(), 1'b1);

    // Smallest limit: one busy poll times out, an immediate ready does not.
    set_poll_limit(16'd1);
    adc_read(1, 12'h123, 1'b0, OP_CONT);
    adc_read(0, 12'h555, 1'b0, OP_CONT);

    // A limit of zero behaves as a single poll.
    set_poll_limit(16'd0);
    adc_read(1, 12'h321, 1'b0, OP_CONT);

    // Largest limit: a long run of busy polls stays far inside it, with no
    // idling on either side.
    set_poll_limit(16'hFFFF);
    quiet = 1'b1;
    adc_read(20, 12'h3C3, 1'b0, OP_CONT);
    quiet = 1'b0;

    // Random part, one poll limit per phase.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0:       lim = 1;
        1:       lim = 3;
        2:       lim = $urandom_range(2, 8);
        3:       lim = 65535;
        4:       lim = 5;
        default: lim = $urandom_range(1, 16);
      endcase
      set_poll_limit(16'(lim));
      if (p == 2) begin
        // Long sink hold-off while the source keeps offering items.
        hold_req = 1'b1;
        quiet = 1'b1;
        dac_write(pick_dac(), 1'b0, OP_CONT);
        adc_read(1, 12'h9E7, 1'b0, OP_CONT);
        quiet = 1'b0;
      end
      // One phase runs without idling on either side.
      quiet = (p == 4);
      phase_end = items_sent + TARGET_ITEMS / PHASE_COUNT;
      while (items_sent < phase_end) random_traffic(lim);
      quiet = 1'b0;
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("bitbang_adc_dac_port_sequencer_tb: done, clean");
    end else begin
      $display("bitbang_adc_dac_port_sequencer_tb: done, errors");
    end
    $finish;
  end

endmodule
